// ----- rtl/isb_pkg.sv -----
package isb_pkg;

  // Width of one frame element
  localparam int unsigned DATA_W = 32;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value into the chain
    logic drain;   // move every entry one cell towards the output
  } cell_ctrl_t;

endpackage

// ----- rtl/isb_cell.sv -----
module isb_cell (
  input  logic                              clk_i,
  input  isb_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              occupied_i,
  input  logic signed [isb_pkg::DATA_W-1:0] in_value_i,
  input  logic                              lower_gt_i,
  input  logic signed [isb_pkg::DATA_W-1:0] lower_value_i,
  input  logic signed [isb_pkg::DATA_W-1:0] upper_value_i,
  output logic                              gt_o,
  output logic signed [isb_pkg::DATA_W-1:0] value_o
);

  logic signed [isb_pkg::DATA_W-1:0] value_d, value_q;

  // An empty cell counts as larger than anything, so the new value lands at
  // the first free cell; equal values stay below the newcomer
  assign gt_o = !occupied_i || (value_q > in_value_i);

  // Shift down on drain, else shift up behind the insertion point or fill it
  always_comb begin
    value_d = value_q;
    priority if (ctrl_i.drain) begin
      value_d = upper_value_i;
    end else if (ctrl_i.insert && gt_o) begin
      value_d = lower_gt_i ? lower_value_i : in_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- rtl/insertion_sort_buffer.sv -----
// Stable insertion sorter for frames of signed 32-bit values.
//
// Input stream (s_axis_*): one value per transfer in tdata, tlast marks the
// final value of a frame. Each value is compared against every stored entry
// in the same cycle and inserted into a row of MAX_ELEMENTS cells, so the
// block takes one value per clock while a frame is being collected. Values
// arriving once the row is full are dropped and the frame is flagged.
//
// Output stream (m_axis_*): after the transfer carrying tlast, tready drops
// and the frame is emitted in ascending order starting the next cycle, one
// value per cycle while the receiver is ready, tlast on the final value and
// tuser set on every value of a frame that lost elements. Each output transfer
// shifts the cell row by one place towards the output; the next frame is
// accepted in the cycle after the final transfer.
//
// A stall on the output simply holds the row and the current value; nothing
// is lost. Reset empties the row and clears the drop flag; no clearing pass
// over the cells is needed since occupancy follows from the element count.
module insertion_sort_buffer #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,   // last_item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic        m_axis_tlast_o,   // last_result
  output logic        m_axis_tuser_o    // [0] overflow
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ELEMENTS);

  localparam logic [0:0] ST_FILL  = 1'b0;
  localparam logic [0:0] ST_DRAIN = 1'b1;

  logic [0:0]       state_d, state_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             drop_d, drop_q;
  logic             in_xfer, out_xfer, full;

  isb_pkg::cell_ctrl_t ctrl;

  logic signed [isb_pkg::DATA_W-1:0] in_value;
  logic signed [isb_pkg::DATA_W-1:0] cell_value [MAX_ELEMENTS];
  logic                              cell_gt    [MAX_ELEMENTS];

  assign in_value = $signed(s_axis_tdata_i);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign full     = (count_q == CNT_FULL);

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.drain  = out_xfer;

  // Row of compare-and-shift cells, cell 0 holding the smallest value
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic                              lower_gt;
    logic signed [isb_pkg::DATA_W-1:0] lower_value;
    logic signed [isb_pkg::DATA_W-1:0] upper_value;

    if (i == 0) begin : g_bottom
      assign lower_gt    = 1'b0;
      assign lower_value = in_value;
    end else begin : g_lower
      assign lower_gt    = cell_gt[i-1];
      assign lower_value = cell_value[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_top
      assign upper_value = cell_value[i];
    end else begin : g_upper
      assign upper_value = cell_value[i+1];
    end

    isb_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (CNT_W'(i) < count_q),
      .in_value_i    (in_value),
      .lower_gt_i    (lower_gt),
      .lower_value_i (lower_value),
      .upper_value_i (upper_value),
      .gt_o          (cell_gt[i]),
      .value_o       (cell_value[i])
    );
  end

  // Collect a frame, then drain it one transfer at a time
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    drop_d  = drop_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_xfer) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (s_axis_tlast_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_xfer) begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_FILL;
            drop_d  = 1'b0;
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_FILL);
  assign m_axis_tvalid_o = (state_q == ST_DRAIN);
  assign m_axis_tdata_o  = cell_value[0];
  assign m_axis_tlast_o  = (count_q == CNT_W'(1));
  assign m_axis_tuser_o  = drop_q;

  // Collecting and draining never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input accepted while a frame drains");

  // A draining frame always holds at least one value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (count_q != '0))
    else $error("drain with empty row");

  // The count never exceeds the row length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("element count beyond capacity");

  // Accepting the final item starts the drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("frame end did not start output");

  // The final output transfer reopens the input and clears the drop flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && m_axis_tlast_o) |=> (s_axis_tready_o && !drop_q && count_q == '0))
    else $error("frame end did not return to collecting");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  localparam int unsigned ROW_DEPTH   = 64;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int          DIR_N       = 19;

  // One frame element as offered on the input stream, with pacing marks
  typedef struct {
    logic [isb_pkg::DATA_W-1:0] value;
    logic                       last;
    bit                         hold_drain;  // offer only once every sorted value is out
    bit                         squeeze;     // receiver holds off when this is taken
    bit                         calm;        // no idling from here on
  } frame_item_t;

  typedef struct {
    logic [isb_pkg::DATA_W-1:0] value;
    logic                       last;
    logic                       overflow;
  } sorted_res_t;

  // Directed frames: single minimum, single maximum, extremes with repeats,
  // a descending run, alternating bit patterns with equal values
  int dir_vals [DIR_N] = '{
    32'h8000_0000,
    32'h7fff_ffff,
    0, -1, 1, 32'h7fff_ffff, 32'h8000_0000, 0, -1,
    100, 50, 0, -50, -100,
    32'haaaa_aaaa, 32'h5555_5555, 7, 7, 7
  };
  // frame ends at elements 0, 1, 8, 13 and 18
  logic [DIR_N-1:0] dir_ends = 19'b100_0010_0001_0000_0011;

  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [isb_pkg::DATA_W-1:0] s_tdata   = '0;
  logic                       s_tlast   = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [isb_pkg::DATA_W-1:0] m_tdata;
  logic                       m_tlast;
  logic                       m_tuser;

  frame_item_t pending [$];
  frame_item_t src_cur;
  sorted_res_t sorted_exp [$];

  // Predictor state: the sorted row of the frame being collected
  int          sort_row [$];
  bit          row_dropped = 1'b0;

  bit          src_fire   = 1'b0;
  bit          hold_req   = 1'b0;
  bit          calm_phase = 1'b0;
  int unsigned src_gap    = 0;
  int unsigned sink_gap   = 0;
  int unsigned hold_left  = 0;
  int unsigned quiet      = 0;
  int unsigned errors     = 0;

  insertion_sort_buffer #(
    .MAX_ELEMENTS(ROW_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // [31:0] value
    .s_axis_tlast_i (s_tlast),   // last_item
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),   // [31:0] sorted_value
    .m_axis_tlast_o (m_tlast),   // last_result
    .m_axis_tuser_o (m_tuser)    // [0] overflow
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Insert one accepted value into the row; on the last one, release the frame
  function automatic void sort_insert(logic [isb_pkg::DATA_W-1:0] val, logic last);
    int          pos;
    sorted_res_t res;
    if (sort_row.size() < ROW_DEPTH) begin
      sort_row.push_back($signed(val));
      pos = sort_row.size() - 1;
      // strict compare keeps equal values in arrival order
      while (pos > 0 && sort_row[pos-1] > $signed(val)) begin
        sort_row[pos] = sort_row[pos-1];
        pos--;
      end
      sort_row[pos] = $signed(val);
    end else begin
      row_dropped = 1'b1;
    end
    if (last) begin
      foreach (sort_row[k]) begin
        res.value    = sort_row[k];
        res.last     = (k == sort_row.size() - 1);
        res.overflow = row_dropped;
        sorted_exp.push_back(res);
      end
      sort_row.delete();
      row_dropped = 1'b0;
    end
  endfunction

  // Full-range values half the time, else small values for ties or the extremes
  function automatic logic [isb_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_frame(int len, bit hold_drain, bit squeeze, bit calm);
    frame_item_t it;
    for (int i = 0; i < len; i++) begin
      it.value      = pick_value();
      it.last       = (i == len - 1);
      it.hold_drain = hold_drain && (i == 0);
      it.squeeze    = squeeze && (i == 0);
      it.calm       = calm;
      pending.push_back(it);
    end
  endtask

  // Source: hold each element until its transfer, idle in bursts between them
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || src_fire)) begin
      if (src_gap != 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending.size() != 0 &&
                   !(pending[0].hold_drain && sorted_exp.size() != 0)) begin
        src_cur = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= src_cur.value;
        s_tlast  <= src_cur.last;
        if (!src_cur.calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 18);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random back-pressure bursts, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm_phase && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 18);
      end
    end
  end

  // Monitor: check output transfers, predict on input transfers, watch for hangs
  always @(posedge clk_i) begin
    sorted_res_t want;
    if (rst_ni) begin
      src_fire = s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (sorted_exp.size() == 0) begin
          $display("%0t: unexpected result: value %0d last %0b overflow %0b",
                   $time, $signed(m_tdata), m_tlast, m_tuser);
          errors++;
        end else begin
          want = sorted_exp.pop_front();
          if (m_tdata !== want.value || m_tlast !== want.last ||
              m_tuser !== want.overflow) begin
            $display("%0t: mismatch: expected value %0d last %0b overflow %0b,",
                     $time, $signed(want.value), want.last, want.overflow);
            $display("%0t:           actual value %0d last %0b overflow %0b",
                     $time, $signed(m_tdata), m_tlast, m_tuser);
            errors++;
          end
        end
      end
      if (src_fire) begin
        if (src_cur.squeeze) hold_req = 1'b1;
        if (src_cur.calm) calm_phase = 1'b1;
        sort_insert(s_tdata, s_tlast);
      end
      if (src_fire || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    frame_item_t it;

    for (int i = 0; i < DIR_N; i++) begin
      it.value      = dir_vals[i];
      it.last       = dir_ends[i];
      it.hold_drain = 1'b0;
      it.squeeze    = 1'b0;
      it.calm       = 1'b0;
      pending.push_back(it);
    end

    // Pause the source until the row is empty, then fill it under a stalled sink
    queue_frame(6, 1'b1, 1'b0, 1'b0);
    queue_frame(8, 1'b0, 1'b1, 1'b0);
    queue_frame(5, 1'b0, 1'b0, 1'b0);

    // Row filled exactly, then a value dropped mid-frame and the last one dropped
    queue_frame(ROW_DEPTH + 2, 1'b1, 1'b0, 1'b0);

    // Closing frames at full rate
    for (int f = 0; f < 3; f++) queue_frame($urandom_range(1, 4), 1'b0, 1'b0, 1'b1);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending.size() != 0 || s_tvalid || sorted_exp.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/isb_pkg.sv
rtl/isb_cell.sv
rtl/insertion_sort_buffer.sv
tb/tb_top.sv
